### src/filtered_signature_matcher_top_defines.svh
// assertion macros shared by the matcher rtl
`ifndef FILTERED_SIGNATURE_MATCHER_TOP_DEFINES_SVH
`define FILTERED_SIGNATURE_MATCHER_TOP_DEFINES_SVH

// same-cycle implication, checked on every clock edge outside reset
`define FSMAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSMAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/fsmat_pkg.sv
// shared constants, types and helpers for the signature matcher
`default_nettype none

package fsmat_pkg;

  localparam int unsigned MAX_SIGNATURE = 512;
  localparam int unsigned CNT_W         = $clog2(MAX_SIGNATURE + 1);
  localparam int unsigned OFFSET_W      = 32;
  localparam int unsigned LEN_W         = 10;

  localparam logic [7:0] BYTE_NUL       = 8'd0;
  localparam logic [7:0] BYTE_TAB       = 8'd9;
  localparam logic [7:0] BYTE_LF        = 8'd10;
  localparam logic [7:0] BYTE_SPACE     = 8'd32;
  localparam logic [7:0] BYTE_SIG_START = 8'd20;
  localparam logic [7:0] BYTE_ENTRY_END = 8'd22;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  // broadcast to every cell of the row
  typedef struct packed {
    logic       clear;
    logic       shift;
    logic       step;
    logic [7:0] data;
  } cell_ctrl_t;

  typedef struct packed {
    logic                match_now;
    logic                found;
    logic [OFFSET_W-1:0] match_end_offset;
    logic [LEN_W-1:0]    signature_length;
    logic                entry_complete;
  } result_t;

  function automatic logic common_drop(input logic [7:0] b);
    return (b == BYTE_NUL) || (b == BYTE_SPACE) || (b == BYTE_LF) || (b == BYTE_TAB);
  endfunction

endpackage

`default_nettype wire

### src/fsmat_in_if.sv
// input channel: one raw byte per beat with opcode and last flag
`default_nettype none

interface fsmat_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output opcode, output data_byte, output last,
                  input ready);
  modport sink (input valid, input opcode, input data_byte, input last,
                output ready);
endinterface

`default_nettype wire

### src/fsmat_out_if.sv
// result channel: one result per accepted input beat
`default_nettype none

interface fsmat_out_if;
  logic        valid;
  logic        ready;
  logic        match_now;
  logic        found;
  logic [31:0] match_end_offset;
  logic [9:0]  signature_length;
  logic        entry_complete;

  modport source (output valid, output match_now, output found,
                  output match_end_offset, output signature_length,
                  output entry_complete, input ready);
  modport sink (input valid, input match_now, input found,
                input match_end_offset, input signature_length,
                input entry_complete, output ready);
endinterface

`default_nettype wire

### src/fsmat_cell.sv
// one matcher cell: a stored signature byte and its partial-match bit
`default_nettype none

module fsmat_cell (
  input  wire                     clk,
  input  wire                     rst,
  input  fsmat_pkg::cell_ctrl_t   ctrl,
  input  wire                     upper,
  input  wire  [7:0]              sig_lo,
  input  wire                     pm_lo,
  input  wire                     pm_hi,
  output logic [7:0]              sig,
  output logic                    pm,
  output logic                    hit
);
  import fsmat_pkg::*;

  // upper: this cell holds the first signature byte or lies above it, so the prefix before it is empty
  assign hit = (upper || pm_hi) && (sig == ctrl.data);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      sig <= sig_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      pm <= 1'b0;
    end else if (ctrl.shift) begin
      pm <= pm_lo;
    end else if (ctrl.step) begin
      pm <= hit;
    end
  end

endmodule

`default_nettype wire

### src/fsmat_row.sv
// row of cells; the signature is held last byte first, so a full match shows at cell 0
`default_nettype none

module fsmat_row (
  input  wire                          clk,
  input  wire                          rst,
  input  fsmat_pkg::cell_ctrl_t        ctrl,
  input  wire  [fsmat_pkg::CNT_W-1:0]  count,
  output logic                         hit
);
  import fsmat_pkg::*;

  logic [7:0] sig   [MAX_SIGNATURE];
  logic       pm    [MAX_SIGNATURE];
  logic       hit_c [MAX_SIGNATURE];

  for (genvar k = 0; k < MAX_SIGNATURE; k++) begin : g_cell
    localparam logic [CNT_W:0] KP1 = (CNT_W + 1)'(k + 1);
    logic       upper;
    logic [7:0] sig_lo;
    logic       pm_lo;
    logic       pm_hi;

    assign upper = ({1'b0, count} <= KP1);

    if (k == 0) begin : g_head
      assign sig_lo = ctrl.data;
      assign pm_lo  = 1'b0;
    end else begin : g_body
      assign sig_lo = sig[k-1];
      assign pm_lo  = pm[k-1];
    end

    if (k == MAX_SIGNATURE - 1) begin : g_top
      assign pm_hi = 1'b1;
    end else begin : g_mid
      assign pm_hi = pm[k+1];
    end

    fsmat_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .upper  (upper),
      .sig_lo (sig_lo),
      .pm_lo  (pm_lo),
      .pm_hi  (pm_hi),
      .sig    (sig[k]),
      .pm     (pm[k]),
      .hit    (hit_c[k])
    );
  end

  assign hit = hit_c[0];

endmodule

`default_nettype wire

### src/filtered_signature_matcher_top.sv
// Filtered signature matcher. Opcode 0 beats load a database entry: a byte 20 starts a
// fresh signature, a byte 22 closes the entry, bytes 0, 32, newline and tab are dropped,
// and up to 512 signature bytes are kept. Opcode 1 beats scan a file: 0, 32, newline, tab,
// 20 and 22 are dropped, and every other byte is compared against all stored
// signature bytes by a row of cells holding one byte and one partial-match bit each.
// One byte is taken every cycle unless the skid entry is full; each input beat yields
// exactly one result beat through a two-entry output buffer, so a stalled result does not
// hold up the input until the second entry is full. found and match_end_offset stick
// at the first match of the current file; a scan beat with last set returns its result
// and then clears the scan state, keeping the signature. No clearing pass after reset.
`default_nettype none
`include "filtered_signature_matcher_top_defines.svh"

module filtered_signature_matcher_top (
  input wire           clk,
  input wire           rst,
  fsmat_in_if.sink     item,
  fsmat_out_if.source  result
);
  import fsmat_pkg::*;

  logic                count_ok;
  logic [CNT_W-1:0]    count, count_next;
  logic                in_sig, in_sig_next;
  logic                found, found_next;
  logic [OFFSET_W-1:0] offset, offset_next;
  logic [OFFSET_W-1:0] first_off, first_off_next;
  logic                accept;
  logic                is_load, is_scan, dropped;
  logic                row_hit, match_now, entry_done, scan_clear;
  cell_ctrl_t          ctrl;
  result_t             res_new, out_buf, skid_buf;
  logic                out_valid, skid_valid, out_take;

  assign accept   = item.valid && item.ready;
  assign is_load  = accept && (item.opcode == OP_LOAD);
  assign is_scan  = accept && (item.opcode == OP_SCAN);
  assign dropped  = common_drop(item.data_byte);
  assign count_ok = (count != '0);

  always_comb begin
    count_next     = count;
    in_sig_next    = in_sig;
    found_next     = found;
    offset_next    = offset;
    first_off_next = first_off;
    entry_done     = 1'b0;
    match_now      = 1'b0;
    scan_clear     = 1'b0;
    ctrl.clear     = 1'b0;
    ctrl.shift     = 1'b0;
    ctrl.step      = 1'b0;
    ctrl.data      = item.data_byte;

    if (is_load && !dropped) begin
      if (item.data_byte == BYTE_SIG_START) begin
        count_next  = '0;
        in_sig_next = 1'b1;
        ctrl.clear  = 1'b1;
      end else if (item.data_byte == BYTE_ENTRY_END) begin
        in_sig_next = 1'b0;
        entry_done  = 1'b1;
      end else if (in_sig && (count < CNT_W'(MAX_SIGNATURE))) begin
        count_next = count + CNT_W'(1);
        ctrl.shift = 1'b1;
      end
    end

    if (is_scan) begin
      offset_next = offset + OFFSET_W'(1);
      if (!dropped && (item.data_byte != BYTE_SIG_START)
          && (item.data_byte != BYTE_ENTRY_END) && count_ok) begin
        ctrl.step = 1'b1;
        match_now = row_hit;
        if (row_hit && !found) begin
          found_next     = 1'b1;
          first_off_next = offset;
        end
      end
      if (item.last) begin
        scan_clear = 1'b1;
        ctrl.clear = 1'b1;
      end
    end
  end

  fsmat_row u_row (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .count (count),
    .hit   (row_hit)
  );

  // result shows values before the end-of-file clear
  assign res_new.match_now        = match_now;
  assign res_new.found            = found_next;
  assign res_new.match_end_offset = first_off_next;
  assign res_new.signature_length = LEN_W'(count_next);
  assign res_new.entry_complete   = entry_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      in_sig    <= 1'b0;
      found     <= 1'b0;
      offset    <= '0;
      first_off <= '0;
    end else begin
      count  <= count_next;
      in_sig <= in_sig_next;
      if (scan_clear) begin
        found     <= 1'b0;
        offset    <= '0;
        first_off <= '0;
      end else begin
        found     <= found_next;
        offset    <= offset_next;
        first_off <= first_off_next;
      end
    end
  end

  // output register plus skid entry
  assign out_take   = out_valid && result.ready;
  assign item.ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !out_take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_buf <= skid_buf;
      end
    end else if (accept) begin
      if (out_valid && !out_take) begin
        skid_buf <= res_new;
      end else begin
        out_buf <= res_new;
      end
    end
  end

  assign result.valid            = out_valid;
  assign result.match_now        = out_buf.match_now;
  assign result.found            = out_buf.found;
  assign result.match_end_offset = out_buf.match_end_offset;
  assign result.signature_length = out_buf.signature_length;
  assign result.entry_complete   = out_buf.entry_complete;

  `FSMAT_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid entry without output entry")
  `FSMAT_ASSERT_NOW(a_match_sets_found, out_valid && result.match_now, result.found,
    "match reported without found")
  `FSMAT_ASSERT_NEXT(a_last_clears_scan, is_scan && item.last,
    !found && (offset == '0) && (first_off == '0), "scan state not cleared after last")
  `FSMAT_ASSERT_NEXT(a_start_clears_count, is_load && (item.data_byte == BYTE_SIG_START),
    (count == '0) && in_sig, "signature start did not restart the store")
  `FSMAT_ASSERT_NOW(a_count_bounded, 1'b1, count <= CNT_W'(MAX_SIGNATURE),
    "signature count beyond capacity")

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// self-checking testbench for the filtered signature matcher
`timescale 1ns / 1ps

module testbench;
  import fsmat_pkg::*;

  class signature_scoreboard;
    // shadow of the matcher state
    bit [7:0]               sig_bytes [MAX_SIGNATURE];
    int unsigned            sig_count;
    bit                     in_sig;
    bit [MAX_SIGNATURE-1:0] partial;
    bit                     found;
    bit [31:0]              scan_off;
    bit [31:0]              first_off;
    result_t                expected_q [$];
    int                     mismatches;

    function new();
      sig_count  = 0;
      in_sig     = 1'b0;
      mismatches = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      partial   = '0;
      found     = 1'b0;
      scan_off  = '0;
      first_off = '0;
    endfunction

    function bit is_blank(bit [7:0] b);
      return b == BYTE_NUL || b == BYTE_SPACE || b == BYTE_LF || b == BYTE_TAB;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // work out the result of one accepted input beat
    function void note_beat(bit op, bit [7:0] b, bit lst);
      result_t   r;
      bit        hit;
      bit        done;
      bit [31:0] off;
      hit  = 1'b0;
      done = 1'b0;
      if (op == OP_LOAD) begin
        if (!is_blank(b)) begin
          if (b == BYTE_SIG_START) begin
            sig_count = 0;
            partial   = '0;
            in_sig    = 1'b1;
          end else if (b == BYTE_ENTRY_END) begin
            in_sig = 1'b0;
            done   = 1'b1;
          end else if (in_sig && sig_count < MAX_SIGNATURE) begin
            sig_bytes[sig_count] = b;
            sig_count++;
          end
        end
      end else begin
        off = scan_off;
        if (!is_blank(b) && b != BYTE_SIG_START && b != BYTE_ENTRY_END && sig_count > 0) begin
          // walk downwards so each bit sees the previous byte's vector
          for (int i = sig_count - 1; i >= 0; i--) begin
            partial[i] = ((i == 0) ? 1'b1 : partial[i-1]) && (sig_bytes[i] == b);
          end
          if (partial[sig_count-1]) begin
            hit = 1'b1;
            if (!found) begin
              found     = 1'b1;
              first_off = off;
            end
          end
        end
        scan_off = off + 1;
      end
      r.match_now        = hit;
      r.found            = found;
      r.match_end_offset = first_off;
      r.signature_length = 10'(sig_count);
      r.entry_complete   = done;
      expected_q.push_back(r);
      if (op == OP_SCAN && lst) clear_scan();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result beat with nothing outstanding");
      end else begin
        want = expected_q.pop_front();
        if (got.match_now !== want.match_now)
          report_mismatch($sformatf("match_now %0b, want %0b", got.match_now, want.match_now));
        if (got.found !== want.found)
          report_mismatch($sformatf("found %0b, want %0b", got.found, want.found));
        if (got.match_end_offset !== want.match_end_offset)
          report_mismatch($sformatf("match_end_offset %0d, want %0d",
                                    got.match_end_offset, want.match_end_offset));
        if (got.signature_length !== want.signature_length)
          report_mismatch($sformatf("signature_length %0d, want %0d",
                                    got.signature_length, want.signature_length));
        if (got.entry_complete !== want.entry_complete)
          report_mismatch($sformatf("entry_complete %0b, want %0b",
                                    got.entry_complete, want.entry_complete));
      end
    endtask
  endclass

  localparam int RANDOM_BEATS = 355;
  localparam int LONG_ENTRY   = MAX_SIGNATURE + 8;
  localparam int SHORT_FILE   = 48;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk = 1'b0;
  logic rst;
  bit   steady = 1'b0;
  int   beats_sent = 0;
  int   cycles = 0;

  signature_scoreboard sb = new();
  result_t             got_beat;

  fsmat_in_if  item_bus ();
  fsmat_out_if result_bus ();

  filtered_signature_matcher_top u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    result_bus.ready <= steady || ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_bus.valid && item_bus.ready)
        sb.note_beat(item_bus.opcode, item_bus.data_byte, item_bus.last);
      if (result_bus.valid && result_bus.ready) begin
        got_beat.match_now        = result_bus.match_now;
        got_beat.found            = result_bus.found;
        got_beat.match_end_offset = result_bus.match_end_offset;
        got_beat.signature_length = result_bus.signature_length;
        got_beat.entry_complete   = result_bus.entry_complete;
        sb.check_result(got_beat);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one beat, with random idle cycles ahead of it
  task automatic send_beat(bit op, bit [7:0] b, bit lst);
    while (!steady && $urandom_range(0, 99) < 25) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid     <= 1'b1;
    item_bus.opcode    <= op;
    item_bus.data_byte <= b;
    item_bus.last      <= lst;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    beats_sent++;
  endtask

  // a byte that survives filtering in both kinds of beat
  function automatic bit [7:0] pick_plain();
    bit [7:0] b;
    do begin
      b = 8'($urandom_range(1, 255));
    end while (b == BYTE_SPACE || b == BYTE_LF || b == BYTE_TAB ||
               b == BYTE_SIG_START || b == BYTE_ENTRY_END);
    return b;
  endfunction

  function automatic bit [7:0] pick_skip(bit with_markers);
    case ($urandom_range(0, with_markers ? 5 : 3))
      0: return BYTE_NUL;
      1: return BYTE_SPACE;
      2: return BYTE_LF;
      3: return BYTE_TAB;
      4: return BYTE_SIG_START;
      default: return BYTE_ENTRY_END;
    endcase
  endfunction

  initial begin
    bit [7:0] cur_sig [$];
    bit [7:0] b;
    int       target;
    int       rand_start;
    int       kind;
    int       roll;
    int       len;
    int       n;

    rst                 = 1'b1;
    item_bus.valid      = 1'b0;
    item_bus.opcode     = OP_LOAD;
    item_bus.data_byte  = '0;
    item_bus.last       = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // scan with nothing stored never matches
    send_beat(OP_SCAN, 8'hff, 1'b0);
    // name byte ahead of the signature start is not kept
    send_beat(OP_LOAD, 8'h41, 1'b0);
    send_beat(OP_LOAD, BYTE_NUL, 1'b0);
    send_beat(OP_LOAD, BYTE_SIG_START, 1'b0);
    send_beat(OP_LOAD, 8'hff, 1'b0);
    send_beat(OP_LOAD, BYTE_TAB, 1'b0);
    send_beat(OP_LOAD, 8'h01, 1'b0);
    send_beat(OP_LOAD, BYTE_SPACE, 1'b0);
    send_beat(OP_LOAD, BYTE_LF, 1'b0);
    // last on a load beat has no effect
    send_beat(OP_LOAD, BYTE_ENTRY_END, 1'b1);
    send_beat(OP_SCAN, 8'hff, 1'b0);
    send_beat(OP_SCAN, BYTE_SIG_START, 1'b0);
    send_beat(OP_SCAN, BYTE_ENTRY_END, 1'b0);
    send_beat(OP_SCAN, BYTE_NUL, 1'b0);
    send_beat(OP_SCAN, 8'h01, 1'b0);
    send_beat(OP_SCAN, 8'hff, 1'b0);
    send_beat(OP_SCAN, 8'h01, 1'b0);
    send_beat(OP_SCAN, 8'h80, 1'b0);
    send_beat(OP_SCAN, 8'h7f, 1'b1);
    // offsets restart after the last beat
    send_beat(OP_SCAN, 8'hff, 1'b0);
    send_beat(OP_SCAN, 8'h01, 1'b1);
    // empty entry
    send_beat(OP_LOAD, BYTE_SIG_START, 1'b0);
    send_beat(OP_LOAD, BYTE_ENTRY_END, 1'b0);
    send_beat(OP_SCAN, 8'hff, 1'b0);
    send_beat(OP_SCAN, 8'h01, 1'b1);

    // entry longer than the store, then a file holding the start of its kept part
    send_beat(OP_LOAD, BYTE_SIG_START, 1'b0);
    for (int k = 0; k < LONG_ENTRY; k++) send_beat(OP_LOAD, 8'(8'h41 + k % 26), 1'b0);
    send_beat(OP_LOAD, BYTE_ENTRY_END, 1'b0);
    for (int k = 0; k < SHORT_FILE; k++)
      send_beat(OP_SCAN, 8'(8'h41 + k % 26), k == SHORT_FILE - 1);

    rand_start = beats_sent;
    target     = beats_sent + RANDOM_BEATS;
    while (beats_sent < target) begin
      steady = (beats_sent - rand_start >= 120) && (beats_sent - rand_start < 240);
      kind   = $urandom_range(0, 99);
      if (kind < 12) begin
        // noise
        n = $urandom_range(1, 6);
        repeat (n) send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
      end else if (kind < 32) begin
        repeat ($urandom_range(0, 3))
          send_beat(OP_LOAD, pick_plain(), 1'($urandom_range(0, 1)));
        send_beat(OP_LOAD, BYTE_SIG_START, 1'b0);
        cur_sig.delete();
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 5) == 0) send_beat(OP_LOAD, pick_skip(1'b0), 1'b0);
          // repeated bytes give overlapping candidates
          b = ($urandom_range(0, 2) == 0 && cur_sig.size() > 0) ?
              cur_sig[$urandom_range(0, cur_sig.size() - 1)] : pick_plain();
          cur_sig.push_back(b);
          send_beat(OP_LOAD, b, 1'b0);
        end
        // now and then the entry is left open
        if ($urandom_range(0, 9) != 0)
          send_beat(OP_LOAD, BYTE_ENTRY_END, 1'($urandom_range(0, 1)));
      end else begin
        n = $urandom_range(3, 30);
        for (int k = 0; k < n; k++) begin
          if (cur_sig.size() > 0 && $urandom_range(0, 7) == 0)
            foreach (cur_sig[j]) send_beat(OP_SCAN, cur_sig[j], 1'b0);
          roll = $urandom_range(0, 9);
          if (roll < 5 && cur_sig.size() > 0)
            b = cur_sig[$urandom_range(0, cur_sig.size() - 1)];
          else if (roll < 7)
            b = pick_skip(1'b1);
          else
            b = 8'($urandom_range(0, 255));
          send_beat(OP_SCAN, b, (k == n - 1) && ($urandom_range(0, 9) != 0));
        end
      end
    end
    steady = 1'b0;
    item_bus.valid <= 1'b0;

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

### files.f
+incdir+src
src/fsmat_pkg.sv
src/fsmat_in_if.sv
src/fsmat_out_if.sv
src/fsmat_cell.sv
src/fsmat_row.sv
src/filtered_signature_matcher_top.sv
tb/sv/testbench.sv
